FILE: src/longest_nondecreasing_subsequence_top_defines.svh
// Assertion macros for the checker file of the subsequence block.
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LNDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lnds check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define LNDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lnds check failed: next-cycle rule");

`endif

FILE: src/lnds_pkg.sv
// Shared constants, state type and controller/datapath interface structs.
`timescale 1ns / 1ps

package lnds_pkg;

   localparam int DEPTH       = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int LEN_W       = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;    // capture request transfer, start a search
      logic search;  // one binary-search step, or commit when done
      logic finish;  // load the result register, clear for next sequence
   } cmd_type;

   typedef struct packed {
      logic done;      // search interval empty, position found
      logic last;      // current element ends the sequence
      logic out_free;  // result register can take a new result
   } status_type;

endpackage

FILE: src/lnds_ctrl.sv
// Controller state machine for the subsequence block.
`timescale 1ns / 1ps

module lnds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lnds_pkg::status_type status,
   output lnds_pkg::cmd_type    cmd
);

   lnds_pkg::state_type state_ff;
   lnds_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lnds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         lnds_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lnds_pkg::ST_SEARCH;
            end
         end
         lnds_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.done) begin
               state_in = status.last ? lnds_pkg::ST_FINISH : lnds_pkg::ST_IDLE;
            end
         end
         lnds_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = lnds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lnds_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/lnds_dp.sv
// Datapath: boundary table, binary-search bounds, length and result register.
`timescale 1ns / 1ps

module lnds_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lnds_pkg::cmd_type                       cmd,
   output lnds_pkg::status_type                    status,
   input  logic signed [31:0]                      req_sample_value,
   input  logic                                    req_is_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [10:0]                             rsp_subsequence_length,
   output logic                                    rsp_overflowed
);

   localparam int VW = lnds_pkg::VALUE_WIDTH;
   localparam int AW = lnds_pkg::ADDR_W;
   localparam int LW = lnds_pkg::LEN_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(lnds_pkg::DEPTH);

   logic signed [VW-1:0] table_mem [lnds_pkg::DEPTH];

   logic signed [VW-1:0] key_ff,  key_in;
   logic signed [VW-1:0] rd_data_ff;
   logic                 last_ff, last_in;
   logic [LW-1:0]        lo_ff,   lo_in;
   logic [LW-1:0]        hi_ff,   hi_in;
   logic [LW-1:0]        mid_ff,  mid_in;
   logic                 pend_ff, pend_in;
   logic [LW-1:0]        len_ff,  len_in;
   logic                 ovf_ff,  ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [10:0]          rsp_len_ff,   rsp_len_in;
   logic                 rsp_ovf_ff,   rsp_ovf_in;

   logic [LW-1:0] lo_c, hi_c, span_c, mid_c;
   logic          done_c;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   // Fold the pending compare into the bounds, then pick the next probe.
   always_comb begin
      lo_c = lo_ff;
      hi_c = hi_ff;
      if (pend_ff) begin
         if (rd_data_ff > key_ff) begin
            hi_c = mid_ff;
         end else begin
            lo_c = mid_ff + LW'(1);
         end
      end
      span_c = hi_c - lo_c;
      mid_c  = lo_c + (span_c >> 1);
      done_c = (lo_c >= hi_c);
   end

   assign status.done     = done_c;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      key_in       = key_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pend_in      = pend_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = mid_c[AW-1:0];
      wr_addr      = lo_c[AW-1:0];

      if (cmd.load) begin
         key_in  = req_sample_value[VW-1:0];
         last_in = req_is_last;
         lo_in   = '0;
         hi_in   = len_ff;
         pend_in = 1'b0;
      end

      if (cmd.search) begin
         lo_in = lo_c;
         hi_in = hi_c;
         if (!done_c) begin
            rd_en   = 1'b1;
            mid_in  = mid_c;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
            if (lo_c != DEPTH_L) begin
               // replace first greater entry, or append at the end
               wr_en = 1'b1;
               if (lo_c == len_ff) begin
                  len_in = len_ff + LW'(1);
               end
            end else begin
               ovf_in = 1'b1;
            end
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = 11'(len_ff);
         rsp_ovf_in   = ovf_ff;
         len_in       = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
      if (wr_en) begin
         table_mem[wr_addr] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      last_ff    <= last_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_subsequence_length = rsp_len_ff;
   assign rsp_overflowed         = rsp_ovf_ff;

endmodule

FILE: src/longest_nondecreasing_subsequence_top.sv
// Top level of the longest non-decreasing subsequence block.
`timescale 1ns / 1ps

// Takes a sequence of signed 32-bit samples, one per request transfer, and
// after the transfer flagged is_last returns one response transfer with the
// length of the longest non-decreasing subsequence of the samples since the
// previous last flag. Internally a sorted table of up to 1024 boundary
// values (one per subsequence length) lives in a single-port memory; each
// sample is placed by binary search for the first entry strictly greater
// than it, then replaces that entry or is appended. Equal samples extend a
// run. Once 1024 entries are held, further appends are dropped, the length
// stays at 1024 and rsp_overflowed is set for that sequence.
// Flow: one item is in work at a time. Each item is accepted in the idle
// state, then searched: one probe read per cycle, each compare folded in
// on the following cycle, and the table write in the final search cycle.
// A last item then passes through the finish state to load the response
// register, and waits there while an earlier response is still stalled.
// The response register holds its transfer until taken, so new samples are
// accepted meanwhile.
// No clearing pass after reset: table entries are only read below the
// current length, so they never need an initial value.

module longest_nondecreasing_subsequence_top (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_is_last,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_subsequence_length,
   output logic               rsp_overflowed
);

   lnds_pkg::cmd_type    cmd;
   lnds_pkg::status_type status;

   // Sequencer: idle / search / finish.
   lnds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table memory, search bounds, length tracking and response register.
   lnds_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_sample_value       (req_sample_value),
      .req_is_last            (req_is_last),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_subsequence_length (rsp_subsequence_length),
      .rsp_overflowed         (rsp_overflowed)
   );

endmodule

FILE: src/lnds_chk.sv
// Port-level checker for the subsequence block, bound to the top level.
`timescale 1ns / 1ps
`include "longest_nondecreasing_subsequence_top_defines.svh"

module lnds_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [10:0]        rsp_subsequence_length,
   input logic               rsp_overflowed
);

   logic req_xfer;
   logic len_full;

   assign req_xfer = req_valid && !req_stall;
   assign len_full = (rsp_subsequence_length == 11'd1024);

   // a stalled response stays offered
   `LNDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // every sequence holds at least its last sample
   `LNDS_ASSERT_NOW(a_len_nonzero, clock, reset, rsp_valid, rsp_subsequence_length != 11'd0)
   // overflow only when the table is full
   `LNDS_ASSERT_NOW(a_ovf_full, clock, reset, rsp_valid && rsp_overflowed, len_full)
   // a response never appears the cycle after a request transfer
   `LNDS_ASSERT_NEXT(a_no_fast_rsp, clock, reset, req_xfer, !$rose(rsp_valid))

endmodule

bind longest_nondecreasing_subsequence_top lnds_chk u_lnds_chk (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_subsequence_length (rsp_subsequence_length),
   .rsp_overflowed         (rsp_overflowed)
);
